>>> rtl/core/xcr_pkg.sv
// Package for the XMODEM checksum receiver: phase and response codes,
// protocol bytes and the structs passed between the receiver's modules.
// No dependencies.
package xcr_pkg;

  // Default number of payload bytes per frame
  localparam int unsigned DataBytesDefault = 128;

  // Register map, by index
  localparam int unsigned RegErrLimit = 0;
  localparam int unsigned RegDestBase = 1;

  // Reset values of the registers
  localparam logic [7:0]  ErrLimitReset = 8'd5;
  localparam logic [31:0] DestBaseReset = 32'd0;

  // Protocol bytes
  localparam logic [7:0] SohByte = 8'h01;
  localparam logic [7:0] EotByte = 8'h04;
  localparam logic [7:0] ByteMax = 8'hFF;

  // Event kinds on the input stream
  typedef enum logic [1:0] {
    EV_BYTE    = 2'd0,
    EV_TIMEOUT = 2'd1,
    EV_START   = 2'd2,
    EV_NONE    = 2'd3
  } event_kind_e;

  // Answers sent back to the sender
  typedef enum logic [1:0] {
    RSP_NONE = 2'd0,
    RSP_ACK  = 2'd1,
    RSP_NAK  = 2'd2,
    RSP_CAN  = 2'd3
  } response_e;

  // Session status reported with every result
  typedef enum logic [1:0] {
    STAT_RUN   = 2'd0,
    STAT_DONE  = 2'd1,
    STAT_ABORT = 2'd2,
    STAT_RSVD  = 2'd3
  } status_e;

  // Receiver phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SEQ    = 3'd2,
    PH_CSEQ   = 3'd3,
    PH_DATA   = 3'd4,
    PH_SUM    = 3'd5,
    PH_DONE   = 3'd6,
    PH_ABORT  = 3'd7
  } phase_e;

  // Configuration register values
  typedef struct packed {
    logic [7:0]  err_limit;
    logic [31:0] dest_base;
  } xcr_cfg_t;

  // One result item
  typedef struct packed {
    response_e   response;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [31:0] write_address;
    logic        frame_commit;
    status_e     session_status;
  } xcr_result_t;

endpackage

>>> rtl/core/xcr_cfg.sv
// APB-style configuration registers of the XMODEM checksum receiver.
// Depends on xcr_pkg for the register map and reset values.
module xcr_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output xcr_pkg::xcr_cfg_t cfg_o
);

  logic [7:0]  err_limit_q, err_limit_d;
  logic [31:0] dest_base_q, dest_base_d;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  // Decode the write request
  always_comb begin
    err_limit_d = err_limit_q;
    dest_base_d = dest_base_q;
    if (wr_en) begin
      if (reg_sel == 1'(xcr_pkg::RegDestBase)) begin
        dest_base_d = pwdata;
      end else begin
        err_limit_d = pwdata[7:0];
      end
    end
  end

  // Hold register values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_limit_q <= xcr_pkg::ErrLimitReset;
      dest_base_q <= xcr_pkg::DestBaseReset;
    end else begin
      err_limit_q <= err_limit_d;
      dest_base_q <= dest_base_d;
    end
  end

  // Return the addressed register
  always_comb begin
    if (reg_sel == 1'(xcr_pkg::RegDestBase)) begin
      prdata = dest_base_q;
    end else begin
      prdata = {24'd0, err_limit_q};
    end
  end

  assign cfg_o.err_limit = err_limit_q;
  assign cfg_o.dest_base = dest_base_q;

endmodule

>>> rtl/core/xcr_proto.sv
// Protocol state and per-event decode of the XMODEM checksum receiver.
// Depends on xcr_pkg for phase, response and result types.
module xcr_proto #(
  parameter int unsigned DATA_BYTES = xcr_pkg::DataBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [1:0]           event_kind_i,
  input  logic [7:0]           rx_byte_i,
  input  xcr_pkg::xcr_cfg_t    cfg_i,
  output xcr_pkg::xcr_result_t result_o
);

  localparam int unsigned IdxW = $clog2(DATA_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DATA_BYTES - 1);
  localparam logic [31:0] FrameStep = 32'(DATA_BYTES);

  xcr_pkg::phase_e phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      exp_seq_q, exp_seq_d;
  logic [7:0]      got_seq_q, got_seq_d;
  logic            seq_ok_q, seq_ok_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      err_q, err_d;
  logic [24:0]     frames_q, frames_d;
  logic [31:0]     offset_q, offset_d;

  logic [7:0]      err_inc;
  logic            err_abort;
  logic            active;
  logic [24:0]     frames_inc;

  // Saturating error count and its cancel decision
  assign err_inc   = (err_q == xcr_pkg::ByteMax) ? err_q : err_q + 8'd1;
  assign err_abort = (err_inc > cfg_i.err_limit);
  assign active    = (phase_q >= xcr_pkg::PH_HEADER) && (phase_q <= xcr_pkg::PH_SUM);
  assign frames_inc = frames_q + 25'd1;

  // Next state and result for one event
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    exp_seq_d = exp_seq_q;
    got_seq_d = got_seq_q;
    seq_ok_d  = seq_ok_q;
    sum_d     = sum_q;
    err_d     = err_q;
    frames_d  = frames_q;
    offset_d  = offset_q;
    result_o.response      = xcr_pkg::RSP_NONE;
    result_o.data_valid    = 1'b0;
    result_o.data_byte     = 8'd0;
    result_o.write_address = 32'd0;
    result_o.frame_commit  = 1'b0;

    case (xcr_pkg::event_kind_e'(event_kind_i))
      xcr_pkg::EV_START: begin
        phase_d   = xcr_pkg::PH_HEADER;
        idx_d     = '0;
        exp_seq_d = 8'd1;
        got_seq_d = 8'd0;
        seq_ok_d  = 1'b0;
        sum_d     = 8'd0;
        err_d     = 8'd0;
        frames_d  = 25'd0;
        offset_d  = 32'd0;
        result_o.response = xcr_pkg::RSP_NAK;
      end
      xcr_pkg::EV_TIMEOUT: begin
        if (active) begin
          err_d = err_inc;
          phase_d = err_abort ? xcr_pkg::PH_ABORT : xcr_pkg::PH_HEADER;
          result_o.response = err_abort ? xcr_pkg::RSP_CAN : xcr_pkg::RSP_NAK;
        end
      end
      xcr_pkg::EV_BYTE: begin
        case (phase_q)
          xcr_pkg::PH_HEADER: begin
            if (rx_byte_i == xcr_pkg::SohByte) begin
              phase_d = xcr_pkg::PH_SEQ;
            end else if (rx_byte_i == xcr_pkg::EotByte) begin
              phase_d = xcr_pkg::PH_DONE;
              result_o.response = xcr_pkg::RSP_ACK;
            end else begin
              err_d = err_inc;
              phase_d = err_abort ? xcr_pkg::PH_ABORT : xcr_pkg::PH_HEADER;
              result_o.response = err_abort ? xcr_pkg::RSP_CAN : xcr_pkg::RSP_NAK;
            end
          end
          xcr_pkg::PH_SEQ: begin
            got_seq_d = rx_byte_i;
            phase_d   = xcr_pkg::PH_CSEQ;
          end
          xcr_pkg::PH_CSEQ: begin
            seq_ok_d = (got_seq_q == ~rx_byte_i);
            sum_d    = 8'd0;
            idx_d    = '0;
            phase_d  = xcr_pkg::PH_DATA;
          end
          xcr_pkg::PH_DATA: begin
            result_o.data_valid    = 1'b1;
            result_o.data_byte     = rx_byte_i;
            result_o.write_address = cfg_i.dest_base + offset_q + 32'(idx_q);
            sum_d = sum_q + rx_byte_i;
            if (idx_q == LastIdx) begin
              phase_d = xcr_pkg::PH_SUM;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          xcr_pkg::PH_SUM: begin
            idx_d = '0;
            if (!seq_ok_q || (rx_byte_i != sum_q)) begin
              err_d = err_inc;
              phase_d = err_abort ? xcr_pkg::PH_ABORT : xcr_pkg::PH_HEADER;
              result_o.response = err_abort ? xcr_pkg::RSP_CAN : xcr_pkg::RSP_NAK;
            end else if (got_seq_q == exp_seq_q) begin
              // New frame: commit and advance the write base
              result_o.response     = xcr_pkg::RSP_ACK;
              result_o.frame_commit = 1'b1;
              exp_seq_d = exp_seq_q + 8'd1;
              frames_d  = frames_inc;
              offset_d  = (frames_inc == 25'd0) ? 32'd0 : offset_q + FrameStep;
              phase_d   = xcr_pkg::PH_HEADER;
            end else if (got_seq_q == exp_seq_q - 8'd1) begin
              // Repeat of the last frame: acknowledge only
              result_o.response = xcr_pkg::RSP_ACK;
              phase_d = xcr_pkg::PH_HEADER;
            end else begin
              result_o.response = xcr_pkg::RSP_CAN;
              phase_d = xcr_pkg::PH_ABORT;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    case (phase_d)
      xcr_pkg::PH_DONE:  result_o.session_status = xcr_pkg::STAT_DONE;
      xcr_pkg::PH_ABORT: result_o.session_status = xcr_pkg::STAT_ABORT;
      default:           result_o.session_status = xcr_pkg::STAT_RUN;
    endcase
  end

  // Advance the protocol state on each processed event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= xcr_pkg::PH_IDLE;
      idx_q     <= '0;
      exp_seq_q <= 8'd1;
      got_seq_q <= 8'd0;
      seq_ok_q  <= 1'b0;
      sum_q     <= 8'd0;
      err_q     <= 8'd0;
      frames_q  <= 25'd0;
      offset_q  <= 32'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      exp_seq_q <= exp_seq_d;
      got_seq_q <= got_seq_d;
      seq_ok_q  <= seq_ok_d;
      sum_q     <= sum_d;
      err_q     <= err_d;
      frames_q  <= frames_d;
      offset_q  <= offset_d;
    end
  end

endmodule

>>> rtl/core/xmodem_checksum_receiver.sv
// Top level of the XMODEM checksum receiver: input and result registers
// around the protocol decode. Depends on xcr_pkg, xcr_cfg and xcr_proto.
//
// Usage: events enter on the s_axis channel, one per request: tuser holds
// the event kind (received byte, receive timeout, start session) and tdata
// the received byte. Every event yields exactly one result on m_axis:
// tuser is the data-valid flag, tdata holds the response to send back,
// the tentative payload byte with its write address, the frame commit
// flag and the session status. The error limit and dest_base registers
// sit on the APB port at byte addresses 0 and 4; the user must write them
// only while idle; the block itself does not enforce this. An event passes
// through the input register, then the result register. Throughput is one
// event per cycle while m_axis accepts results, set by the combinational
// protocol decode and state update. After reset the receiver is idle and
// waits for a start event; bytes and timeouts are answered with no response
// until then. When the result side stalls, the result register holds, the
// input register fills and s_axis_tready drops; nothing is lost or repeated.
module xmodem_checksum_receiver #(
  parameter int unsigned DATA_BYTES = xcr_pkg::DataBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input events
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] event_kind
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] response, [9:2] data_byte, [41:10] write_address,
  // [42] frame_commit, [44:43] session_status, [47:45] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] data_valid
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  xcr_pkg::xcr_cfg_t    cfg;
  xcr_pkg::xcr_result_t res_d, res_q;

  logic       in_valid_q, in_valid_d;
  logic [1:0] in_kind_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  logic       step;
  logic       in_take;

  // Process when an event waits and the result register is free or being read
  assign step          = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | step;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  assign in_valid_d  = in_take | (in_valid_q & ~step);
  assign out_valid_d = step | (out_valid_q & ~m_axis_tready);

  // Hold control state of both registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input request
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  xcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  xcr_proto #(
    .DATA_BYTES (DATA_BYTES)
  ) u_proto (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .event_kind_i (in_kind_q),
    .rx_byte_i    (in_byte_q),
    .cfg_i        (cfg),
    .result_o     (res_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.data_valid;
  assign m_axis_tdata  = {3'd0, res_q.session_status, res_q.frame_commit,
                          res_q.write_address, res_q.data_byte, res_q.response};

endmodule
